FILE: design/gnlm_pkg.sv
// Shared types, codes and the exponential weight table entry function for the guided NLM filter.
package gnlm_pkg;

  localparam int unsigned IDXW = 12;
  localparam int unsigned SMPW = 16;
  localparam int unsigned CIW  = 3;
  localparam int unsigned CDW  = 16;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  localparam logic [CIW-1:0] CFG_FRAME_WIDTH     = 3'd0;
  localparam logic [CIW-1:0] CFG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CIW-1:0] CFG_FILTER_STRENGTH = 3'd2;
  localparam logic [CIW-1:0] CFG_PATCH_RADIUS    = 3'd3;
  localparam logic [CIW-1:0] CFG_SEARCH_RADIUS   = 3'd4;

  localparam logic [6:0]  RST_FRAME_WIDTH     = 7'd64;
  localparam logic [6:0]  RST_FRAME_HEIGHT    = 7'd64;
  localparam logic [15:0] RST_FILTER_STRENGTH = 16'd256;
  localparam logic [1:0]  RST_PATCH_RADIUS    = 2'd1;
  localparam logic [2:0]  RST_SEARCH_RADIUS   = 3'd3;

  localparam logic [63:0] EXP_STEP = 64'd4034748387;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CDIV,
    ST_NB,
    ST_PADDR,
    ST_PACC,
    ST_WSET,
    ST_WOVF,
    ST_WDIV,
    ST_WLOOK,
    ST_WACC,
    ST_FIN,
    ST_FDIV,
    ST_CEN,
    ST_EMIT
  } state_e;

  function automatic logic [15:0] exp_entry(input int unsigned idx);
    logic [63:0] acc;
    logic [63:0] e;
    acc = 64'h1_0000_0000;
    for (int unsigned k = 0; k < idx; k++) begin
      acc = (acc * EXP_STEP + 64'h8000_0000) >> 32;
    end
    e = (acc + 64'd32768) >> 16;
    return (e > 64'd65535) ? 16'hFFFF : e[15:0];
  endfunction

endpackage

FILE: design/gnlm_req_if.sv
// Input item channel: pixel loads and filter requests.
interface gnlm_req_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [gnlm_pkg::IDXW-1:0]      pixel_index;
  logic [gnlm_pkg::SMPW-1:0]      noisy_value;
  logic [gnlm_pkg::SMPW-1:0]      guide_value;

  modport source(output valid, kind, pixel_index, noisy_value, guide_value, input ready);
  modport sink(input valid, kind, pixel_index, noisy_value, guide_value, output ready);
endinterface

FILE: design/gnlm_res_if.sv
// Result item channel: filtered pixels.
interface gnlm_res_if;
  logic                           valid;
  logic                           ready;
  logic [gnlm_pkg::IDXW-1:0]      result_index;
  logic [gnlm_pkg::SMPW-1:0]      filtered_value;
  logic                           index_error;

  modport source(output valid, result_index, filtered_value, index_error, input ready);
  modport sink(input valid, result_index, filtered_value, index_error, output ready);
endinterface

FILE: design/gnlm_cfg_if.sv
// Configuration write channel: register index and write data.
interface gnlm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gnlm_pkg::CIW-1:0]       index;
  logic [gnlm_pkg::CDW-1:0]       data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: design/gnlm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gnlm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/guided_non_local_means_filter.sv
// Guided non-local-means denoiser top level: frame stores, sequencer, shared divider.
//
//   channel  direction  handshake     payload
//   in_i     sink       valid/ready   kind, pixel_index, noisy_value, guide_value
//   out_o    source     valid/ready   result_index, filtered_value, index_error
//   cfg_i    sink       valid/ready   index, data (ready is always high)
//
// A load writes the frame stores as it is taken. A request first splits the index with a division,
// then visits each search position, and for each in-frame neighbour each patch offset, with one
// accumulate step per valid pair and a weight division and lookup (the division is skipped when
// the weight underflows to zero); a final rounding division (skipped when the weight sum is zero)
// and the emit follow. Out-of-frame requests go straight to the emit. Reset clears control and
// configuration only; frame stores hold garbage until loaded. A stalled result holds in the output
// register while further items are taken; the next result waits in the emit state for it to leave.
module guided_non_local_means_filter #(
  parameter int unsigned MAX_WIDTH         = 64,
  parameter int unsigned MAX_HEIGHT        = 64,
  parameter int unsigned MAX_PATCH_RADIUS  = 3,
  parameter int unsigned MAX_SEARCH_RADIUS = 7,
  parameter int unsigned EXP_TABLE_DEPTH   = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  gnlm_req_if.sink   in_i,
  gnlm_res_if.source out_o,
  gnlm_cfg_if.sink   cfg_i
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned MXD   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned CMAX  = MXD + MAX_SEARCH_RADIUS + MAX_PATCH_RADIUS;
  localparam int unsigned CW    = $clog2(CMAX + 1) + 1;
  localparam int unsigned MW    = CW + 7;
  localparam int unsigned OW    = $clog2(MAX_SEARCH_RADIUS + MAX_PATCH_RADIUS + 1) + 1;
  localparam int unsigned PN    = (2 * MAX_PATCH_RADIUS + 1) * (2 * MAX_PATCH_RADIUS + 1);
  localparam int unsigned PW    = $clog2(PN + 1);
  localparam int unsigned SN    = (2 * MAX_SEARCH_RADIUS + 1) * (2 * MAX_SEARCH_RADIUS + 1);
  localparam int unsigned SCW   = $clog2(SN + 1);
  localparam int unsigned DSW   = 32 + PW;
  localparam int unsigned DVW   = PW + 36;
  localparam int unsigned QW    = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned SWW   = 16 + SCW;
  localparam int unsigned SVW   = 32 + SCW;
  localparam int unsigned UWA   = DVW + QW;
  localparam int unsigned UWB   = SVW + 1;
  localparam int unsigned UW    = (UWA > UWB) ? UWA : UWB;
  localparam int unsigned QTW   = (QW > 16) ? QW : 16;
  localparam int unsigned NW    = $clog2(QTW + 1);

  logic [15:0] exp_tab [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [15:0] ENTRY = gnlm_pkg::exp_entry(g);
    assign exp_tab[g] = ENTRY;
  end

  // configuration
  logic [6:0]  cw_q, cw_d, ch_q, ch_d;
  logic [15:0] cs_q, cs_d;
  logic [1:0]  cpr_q, cpr_d;
  logic [2:0]  csr_q, csr_d;

  always_comb begin
    cw_d  = cw_q;
    ch_d  = ch_q;
    cs_d  = cs_q;
    cpr_d = cpr_q;
    csr_d = csr_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        gnlm_pkg::CFG_FRAME_WIDTH:     cw_d  = cfg_i.data[6:0];
        gnlm_pkg::CFG_FRAME_HEIGHT:    ch_d  = cfg_i.data[6:0];
        gnlm_pkg::CFG_FILTER_STRENGTH: cs_d  = cfg_i.data;
        gnlm_pkg::CFG_PATCH_RADIUS:    cpr_d = cfg_i.data[1:0];
        gnlm_pkg::CFG_SEARCH_RADIUS:   csr_d = cfg_i.data[2:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  logic [6:0]            wc, hc;
  logic signed [CW-1:0]  wcs, hcs;
  logic signed [OW-1:0]  pr, sr;
  logic [13:0]           area;

  assign wc  = (cw_q == 7'd0) ? 7'd1 : ((int'(cw_q) > MAX_WIDTH) ? 7'(MAX_WIDTH) : cw_q);
  assign hc  = (ch_q == 7'd0) ? 7'd1 : ((int'(ch_q) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : ch_q);
  assign wcs = CW'(wc);
  assign hcs = CW'(hc);
  assign pr  = (int'(cpr_q) > MAX_PATCH_RADIUS) ? OW'(MAX_PATCH_RADIUS) : OW'(cpr_q);
  assign sr  = (int'(csr_q) > MAX_SEARCH_RADIUS) ? OW'(MAX_SEARCH_RADIUS) : OW'(csr_q);
  assign area = 14'(wc) * 14'(hc);

  // sequencer registers
  gnlm_pkg::state_e state_q, state_d;
  logic                 ovalid_q, ovalid_d;
  logic [11:0]          oidx_q, oidx_d;
  logic [15:0]          oval_q, oval_d;
  logic                 oerr_q, oerr_d;
  logic [11:0]          idx_q, idx_d;
  logic                 err_q, err_d;
  logic [15:0]          res_q, res_d;
  logic [31:0]          hsq_q, hsq_d;
  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [OW-1:0] sy_q, sy_d, sx_q, sx_d, py_q, py_d, px_q, px_d;
  logic [AW-1:0]        nb_addr_q, nb_addr_d;
  logic [PW-1:0]        pcnt_q, pcnt_d;
  logic [DSW-1:0]       dist_q, dist_d;
  logic [DVW-1:0]       dv_q, dv_d;
  logic                 ovf_q, ovf_d;
  logic [15:0]          wt_q, wt_d;
  logic [SVW-1:0]       sv_q, sv_d;
  logic [SWW-1:0]       sw_q, sw_d;
  logic [UW-1:0]        rem_q, rem_d, dsh_q, dsh_d;
  logic [QTW-1:0]       quo_q, quo_d;
  logic [NW-1:0]        cnt_q, cnt_d;

  // shared restoring divider step
  logic           div_ge, div_last;
  logic [UW-1:0]  div_rem;
  logic [QTW-1:0] div_quo;

  assign div_ge   = rem_q >= dsh_q;
  assign div_rem  = div_ge ? (rem_q - dsh_q) : rem_q;
  assign div_quo  = {quo_q[QTW-2:0], div_ge};
  assign div_last = cnt_q == NW'(1);

  // coordinates
  logic signed [CW-1:0] ny, nx, cy, cx, qy, qx;
  logic                 nb_in, pair_ok, s_last, p_last;
  logic [MW-1:0]        mul_n, mul_c, mul_q;
  logic [AW-1:0]        addr_n, addr_c, addr_q;

  assign ny = y_q + CW'(sy_q);
  assign nx = x_q + CW'(sx_q);
  assign cy = y_q + CW'(py_q);
  assign cx = x_q + CW'(px_q);
  assign qy = ny + CW'(py_q);
  assign qx = nx + CW'(px_q);

  assign nb_in   = (ny >= 0) && (ny < hcs) && (nx >= 0) && (nx < wcs);
  assign pair_ok = (cy >= 0) && (cy < hcs) && (qy >= 0) && (qy < hcs) &&
                   (cx >= 0) && (cx < wcs) && (qx >= 0) && (qx < wcs);
  assign s_last  = (sx_q == sr) && (sy_q == sr);
  assign p_last  = (px_q == pr) && (py_q == pr);

  assign mul_n  = $unsigned(ny) * wc;
  assign mul_c  = $unsigned(cy) * wc;
  assign mul_q  = $unsigned(qy) * wc;
  assign addr_n = AW'(mul_n + MW'($unsigned(nx)));
  assign addr_c = AW'(mul_c + MW'($unsigned(cx)));
  assign addr_q = AW'(mul_q + MW'($unsigned(qx)));

  // frame stores
  logic          st_we;
  logic [AW-1:0] st_waddr, nz_raddr;
  logic [15:0]   gc_rd, gn_rd, nz_rd;
  logic          in_acc, in_frame;

  assign in_i.ready = state_q == gnlm_pkg::ST_IDLE;
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_frame   = 14'(in_i.pixel_index) < area;
  assign st_we      = in_acc && (in_i.kind == gnlm_pkg::KIND_LOAD) && in_frame;
  assign st_waddr   = AW'(in_i.pixel_index);
  assign nz_raddr   = (state_q == gnlm_pkg::ST_FIN) ? AW'(idx_q) : nb_addr_q;

  gnlm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_noisy (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(in_i.noisy_value),
    .raddr_i(nz_raddr), .rdata_o(nz_rd)
  );

  gnlm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_guide_c (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(in_i.guide_value),
    .raddr_i(addr_c), .rdata_o(gc_rd)
  );

  gnlm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_guide_n (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(in_i.guide_value),
    .raddr_i(addr_q), .rdata_o(gn_rd)
  );

  // datapath helpers
  logic [16:0]    gdiff;
  logic [15:0]    gabs;
  logic [31:0]    gsq, nzw, hsq_raw;
  logic [PW+31:0] cnt_hsq;
  logic [QW-1:0]  tq;
  logic [15:0]    tab_wt;

  assign gdiff   = {1'b0, gc_rd} - {1'b0, gn_rd};
  assign gabs    = gdiff[16] ? 16'(-gdiff) : gdiff[15:0];
  assign gsq     = gabs * gabs;
  assign nzw     = nz_rd * wt_q;
  assign hsq_raw = cs_q * cs_q;
  assign cnt_hsq = pcnt_q * hsq_q;
  assign tq      = quo_q[QW-1:0];
  assign tab_wt  = (ovf_q || (int'(tq) >= EXP_TABLE_DEPTH)) ? 16'd0 : exp_tab[tq];

  always_comb begin
    state_d   = state_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    oidx_d    = oidx_q;
    oval_d    = oval_q;
    oerr_d    = oerr_q;
    idx_d     = idx_q;
    err_d     = err_q;
    res_d     = res_q;
    hsq_d     = hsq_q;
    x_d       = x_q;
    y_d       = y_q;
    sy_d      = sy_q;
    sx_d      = sx_q;
    py_d      = py_q;
    px_d      = px_q;
    nb_addr_d = nb_addr_q;
    pcnt_d    = pcnt_q;
    dist_d    = dist_q;
    dv_d      = dv_q;
    ovf_d     = ovf_q;
    wt_d      = wt_q;
    sv_d      = sv_q;
    sw_d      = sw_q;
    rem_d     = rem_q;
    dsh_d     = dsh_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;

    case (state_q)
      gnlm_pkg::ST_IDLE: begin
        if (in_acc && (in_i.kind == gnlm_pkg::KIND_REQUEST)) begin
          idx_d = in_i.pixel_index;
          hsq_d = (hsq_raw == 32'd0) ? 32'd1 : hsq_raw;
          if (in_frame) begin
            err_d   = 1'b0;
            rem_d   = UW'(in_i.pixel_index);
            dsh_d   = UW'(wc) << 11;
            quo_d   = '0;
            cnt_d   = NW'(12);
            state_d = gnlm_pkg::ST_CDIV;
          end else begin
            err_d   = 1'b1;
            res_d   = '0;
            state_d = gnlm_pkg::ST_EMIT;
          end
        end
      end

      gnlm_pkg::ST_CDIV: begin
        rem_d = div_rem;
        quo_d = div_quo;
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - NW'(1);
        if (div_last) begin
          y_d     = CW'(div_quo);
          x_d     = CW'(div_rem);
          sy_d    = -sr;
          sx_d    = -sr;
          sv_d    = '0;
          sw_d    = '0;
          state_d = gnlm_pkg::ST_NB;
        end
      end

      gnlm_pkg::ST_NB: begin
        if (nb_in) begin
          nb_addr_d = addr_n;
          py_d      = -pr;
          px_d      = -pr;
          dist_d    = '0;
          pcnt_d    = '0;
          state_d   = gnlm_pkg::ST_PADDR;
        end else if (s_last) begin
          state_d = gnlm_pkg::ST_FIN;
        end else if (sx_q == sr) begin
          sx_d = -sr;
          sy_d = sy_q + OW'(1);
        end else begin
          sx_d = sx_q + OW'(1);
        end
      end

      gnlm_pkg::ST_PADDR: begin
        if (pair_ok) begin
          state_d = gnlm_pkg::ST_PACC;
        end else if (p_last) begin
          state_d = gnlm_pkg::ST_WSET;
        end else if (px_q == pr) begin
          px_d = -pr;
          py_d = py_q + OW'(1);
        end else begin
          px_d = px_q + OW'(1);
        end
      end

      gnlm_pkg::ST_PACC: begin
        dist_d = dist_q + DSW'(gsq);
        pcnt_d = pcnt_q + PW'(1);
        if (p_last) begin
          state_d = gnlm_pkg::ST_WSET;
        end else begin
          state_d = gnlm_pkg::ST_PADDR;
          if (px_q == pr) begin
            px_d = -pr;
            py_d = py_q + OW'(1);
          end else begin
            px_d = px_q + OW'(1);
          end
        end
      end

      gnlm_pkg::ST_WSET: begin
        dv_d    = {cnt_hsq, 4'b0000};
        state_d = gnlm_pkg::ST_WOVF;
      end

      gnlm_pkg::ST_WOVF: begin
        ovf_d = (DVW'(dist_q) >> QW) >= dv_q;
        if ((DVW'(dist_q) >> QW) >= dv_q) begin
          state_d = gnlm_pkg::ST_WLOOK;
        end else begin
          rem_d   = UW'(dist_q);
          dsh_d   = UW'(dv_q) << (QW - 1);
          quo_d   = '0;
          cnt_d   = NW'(QW);
          state_d = gnlm_pkg::ST_WDIV;
        end
      end

      gnlm_pkg::ST_WDIV: begin
        rem_d = div_rem;
        quo_d = div_quo;
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - NW'(1);
        if (div_last) begin
          state_d = gnlm_pkg::ST_WLOOK;
        end
      end

      gnlm_pkg::ST_WLOOK: begin
        wt_d    = tab_wt;
        state_d = gnlm_pkg::ST_WACC;
      end

      gnlm_pkg::ST_WACC: begin
        sv_d = sv_q + SVW'(nzw);
        sw_d = sw_q + SWW'(wt_q);
        if (s_last) begin
          state_d = gnlm_pkg::ST_FIN;
        end else begin
          state_d = gnlm_pkg::ST_NB;
          if (sx_q == sr) begin
            sx_d = -sr;
            sy_d = sy_q + OW'(1);
          end else begin
            sx_d = sx_q + OW'(1);
          end
        end
      end

      gnlm_pkg::ST_FIN: begin
        if (sw_q == '0) begin
          state_d = gnlm_pkg::ST_CEN;
        end else begin
          rem_d   = UW'(sv_q) + UW'(sw_q >> 1);
          dsh_d   = UW'(sw_q) << 15;
          quo_d   = '0;
          cnt_d   = NW'(16);
          state_d = gnlm_pkg::ST_FDIV;
        end
      end

      gnlm_pkg::ST_FDIV: begin
        rem_d = div_rem;
        quo_d = div_quo;
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - NW'(1);
        if (div_last) begin
          res_d   = div_quo[15:0];
          state_d = gnlm_pkg::ST_EMIT;
        end
      end

      gnlm_pkg::ST_CEN: begin
        res_d   = nz_rd;
        state_d = gnlm_pkg::ST_EMIT;
      end

      gnlm_pkg::ST_EMIT: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          oidx_d   = idx_q;
          oval_d   = res_q;
          oerr_d   = err_q;
          state_d  = gnlm_pkg::ST_IDLE;
        end
      end

      default: state_d = gnlm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gnlm_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
      cw_q     <= gnlm_pkg::RST_FRAME_WIDTH;
      ch_q     <= gnlm_pkg::RST_FRAME_HEIGHT;
      cs_q     <= gnlm_pkg::RST_FILTER_STRENGTH;
      cpr_q    <= gnlm_pkg::RST_PATCH_RADIUS;
      csr_q    <= gnlm_pkg::RST_SEARCH_RADIUS;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      cw_q     <= cw_d;
      ch_q     <= ch_d;
      cs_q     <= cs_d;
      cpr_q    <= cpr_d;
      csr_q    <= csr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oidx_q    <= oidx_d;
    oval_q    <= oval_d;
    oerr_q    <= oerr_d;
    idx_q     <= idx_d;
    err_q     <= err_d;
    res_q     <= res_d;
    hsq_q     <= hsq_d;
    x_q       <= x_d;
    y_q       <= y_d;
    sy_q      <= sy_d;
    sx_q      <= sx_d;
    py_q      <= py_d;
    px_q      <= px_d;
    nb_addr_q <= nb_addr_d;
    pcnt_q    <= pcnt_d;
    dist_q    <= dist_d;
    dv_q      <= dv_d;
    ovf_q     <= ovf_d;
    wt_q      <= wt_d;
    sv_q      <= sv_d;
    sw_q      <= sw_d;
    rem_q     <= rem_d;
    dsh_q     <= dsh_d;
    quo_q     <= quo_d;
    cnt_q     <= cnt_d;
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.result_index   = oidx_q;
  assign out_o.filtered_value = oval_q;
  assign out_o.index_error    = oerr_q;

endmodule

FILE: design/gnlm_checker.sv
// Port-level checker for the guided NLM filter and its bind to the top level.
module gnlm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_index,
  input logic [15:0] out_value,
  input logic        out_err
);

  a_req_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_kind == gnlm_pkg::KIND_REQUEST) |=> !in_ready)
    else $error("input still ready after a request item");

  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_kind == gnlm_pkg::KIND_LOAD) |=> in_ready)
    else $error("load item did not finish in one cycle");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_err |-> out_value == 16'd0)
    else $error("flagged item carries a nonzero value");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_index)
      && $stable(out_err))
    else $error("stalled result item changed");

endmodule

bind guided_non_local_means_filter gnlm_checker u_gnlm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_kind   (in_i.kind),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_index (out_o.result_index),
  .out_value (out_o.filtered_value),
  .out_err   (out_o.index_error)
);
